[rtl/fdr_pkg.sv]
// Package for the Fresnel reflectance core: fixed-point widths and constants.
// Used by the top level and the bench scoreboard; depends on nothing.
`default_nettype none
package fdr_pkg;
  localparam int unsigned DataW  = 16;  // input and output field width
  localparam int unsigned SiW    = 16;  // incident sine root width
  localparam int unsigned CtW    = 29;  // transmitted cosine root width
  localparam int unsigned QW     = 17;  // ratio magnitude width, Q16
  localparam int unsigned Sum1W  = 33;  // parallel ratio denominator
  localparam int unsigned Sum2W  = 46;  // perpendicular ratio denominator
  localparam logic [15:0] Q15_ONE = 16'h8000;
  localparam logic [16:0] Q16_ONE = 17'h10000;
endpackage
`default_nettype wire

[rtl/fresnel_dielectric_reflectance_core.sv]
// Top level of the unpolarized Fresnel reflectance core.
// Uses fdr_pkg, fdr_sqrt_cell and fdr_div_cell.
//
// Usage:
//   Input request: in_cos_incident (Q1.15, clamped to 1.0) and
//   in_eta_ratio (Q3.13) under in_valid/in_ready. Result request:
//   out_reflectance (Q1.15) and out_total_internal under
//   out_valid/out_ready.
//   Throughput is one request per cycle. The chain holds, in order:
//   1 input stage, 16 sine root cells, 2 stages for the transmitted
//   sine and its square, 29 cosine root cells, 2 stages for the ratio
//   terms, 17 divider cells, 1 squaring stage and the output register.
//   The whole pipe advances together; when the receiver stalls with a
//   result held, every stage holds and in_ready drops in the same cycle.
//   The block has no state between requests. Reset clears all valid bits;
//   in_ready is high right after reset.
`default_nettype none
module fresnel_dielectric_reflectance_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_cos_incident,
  input  wire logic [15:0] in_eta_ratio,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_reflectance,
  output logic             out_total_internal
);
  localparam int unsigned SiW   = fdr_pkg::SiW;
  localparam int unsigned CtW   = fdr_pkg::CtW;
  localparam int unsigned QW    = fdr_pkg::QW;
  localparam int unsigned Sum1W = fdr_pkg::Sum1W;
  localparam int unsigned Sum2W = fdr_pkg::Sum2W;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // input stage: clamp cosine, form 1 - c^2 in Q30
  logic [15:0] c_in;
  logic [31:0] cc;
  logic        s0_v_r;
  logic [15:0] s0_c_r, s0_e_r;
  logic [31:0] s0_d_r;
  assign c_in = (in_cos_incident > fdr_pkg::Q15_ONE) ? fdr_pkg::Q15_ONE : in_cos_incident;
  assign cc   = 32'(c_in) * 32'(c_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s0_c_r <= c_in;
      s0_e_r <= in_eta_ratio;
      s0_d_r <= 32'h4000_0000 - cc;
    end
  end

  // incident sine root chain
  logic            sa_v    [0:SiW];
  logic [SiW+1:0]  sa_rem  [0:SiW];
  logic [SiW-1:0]  sa_root [0:SiW];
  logic [2*SiW-1:0] sa_rad [0:SiW];
  logic [31:0]     sa_side [0:SiW];
  assign sa_v[0]    = s0_v_r;
  assign sa_rem[0]  = '0;
  assign sa_root[0] = '0;
  assign sa_rad[0]  = s0_d_r;
  assign sa_side[0] = {s0_c_r, s0_e_r};

  generate
    for (genvar i = 0; i < SiW; i++) begin : g_sqrt_si
      fdr_sqrt_cell #(.RW(SiW), .SW(32)) u_cell (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(sa_v[i]), .in_rem(sa_rem[i]), .in_root(sa_root[i]),
        .in_rad(sa_rad[i]), .in_side(sa_side[i]),
        .out_valid(sa_v[i+1]), .out_rem(sa_rem[i+1]), .out_root(sa_root[i+1]),
        .out_rad(sa_rad[i+1]), .out_side(sa_side[i+1])
      );
    end
  endgenerate

  // transmitted sine st = e * si, Q28
  logic        s2_v_r, s2_tir_r;
  logic [15:0] s2_c_r, s2_e_r;
  logic [31:0] s2_st_r, st_w;
  assign st_w = 32'(sa_side[SiW][15:0]) * 32'(sa_root[SiW]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= sa_v[SiW];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_c_r   <= sa_side[SiW][31:16];
      s2_e_r   <= sa_side[SiW][15:0];
      s2_st_r  <= st_w;
      s2_tir_r <= (st_w[31:28] != 4'd0);
    end
  end

  // radicand 1 - st^2 in Q56
  logic        s3_v_r, s3_tir_r;
  logic [15:0] s3_c_r, s3_e_r;
  logic [56:0] s3_d_r;
  logic [55:0] stsq;
  assign stsq = 56'(s2_st_r[27:0]) * 56'(s2_st_r[27:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_c_r   <= s2_c_r;
      s3_e_r   <= s2_e_r;
      s3_tir_r <= s2_tir_r;
      s3_d_r   <= {1'b1, 56'd0} - {1'b0, stsq};
    end
  end

  // transmitted cosine root chain
  logic            sb_v    [0:CtW];
  logic [CtW+1:0]  sb_rem  [0:CtW];
  logic [CtW-1:0]  sb_root [0:CtW];
  logic [2*CtW-1:0] sb_rad [0:CtW];
  logic [32:0]     sb_side [0:CtW];
  assign sb_v[0]    = s3_v_r;
  assign sb_rem[0]  = '0;
  assign sb_root[0] = '0;
  assign sb_rad[0]  = {1'b0, s3_d_r};
  assign sb_side[0] = {s3_tir_r, s3_c_r, s3_e_r};

  generate
    for (genvar i = 0; i < CtW; i++) begin : g_sqrt_ct
      fdr_sqrt_cell #(.RW(CtW), .SW(33)) u_cell (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(sb_v[i]), .in_rem(sb_rem[i]), .in_root(sb_root[i]),
        .in_rad(sb_rad[i]), .in_side(sb_side[i]),
        .out_valid(sb_v[i+1]), .out_rem(sb_rem[i+1]), .out_root(sb_root[i+1]),
        .out_rad(sb_rad[i+1]), .out_side(sb_side[i+1])
      );
    end
  endgenerate

  // ratio operands: a1 = e*c, b1 = ct, a2 = c<<26, b2 = e*ct
  logic        s5_v_r, s5_tir_r;
  logic [31:0] s5_a1_r;
  logic [28:0] s5_b1_r;
  logic [41:0] s5_a2_r;
  logic [44:0] s5_b2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= sb_v[CtW];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s5_tir_r <= sb_side[CtW][32];
      s5_a1_r  <= 32'(sb_side[CtW][15:0]) * 32'(sb_side[CtW][31:16]);
      s5_b1_r  <= sb_root[CtW];
      s5_a2_r  <= {sb_side[CtW][31:16], 26'd0};
      s5_b2_r  <= 45'(sb_side[CtW][15:0]) * 45'(sb_root[CtW]);
    end
  end

  // differences and sums
  logic             s6_v_r, s6_tir_r, s6_z1_r, s6_z2_r;
  logic [Sum1W-1:0] s6_d1_r, s6_s1_r, s1_w;
  logic [Sum2W-1:0] s6_d2_r, s6_s2_r, s2_w;
  assign s1_w = {1'b0, s5_a1_r} + Sum1W'(s5_b1_r);
  assign s2_w = Sum2W'(s5_a2_r) + Sum2W'(s5_b2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (en) begin
      s6_v_r <= s5_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s6_tir_r <= s5_tir_r;
      s6_s1_r  <= s1_w;
      s6_s2_r  <= s2_w;
      s6_z1_r  <= (s1_w == '0);
      s6_z2_r  <= (s2_w == '0);
      s6_d1_r  <= (Sum1W'(s5_a1_r) > Sum1W'(s5_b1_r))
                  ? Sum1W'(s5_a1_r) - Sum1W'(s5_b1_r)
                  : Sum1W'(s5_b1_r) - Sum1W'(s5_a1_r);
      s6_d2_r  <= (Sum2W'(s5_a2_r) > Sum2W'(s5_b2_r))
                  ? Sum2W'(s5_a2_r) - Sum2W'(s5_b2_r)
                  : Sum2W'(s5_b2_r) - Sum2W'(s5_a2_r);
    end
  end

  // two divider chains side by side
  logic             da_v    [0:QW];
  logic [Sum1W-1:0] da_rem  [0:QW];
  logic [Sum1W-1:0] da_den  [0:QW];
  logic [QW-1:0]    da_q    [0:QW];
  logic [1:0]       da_side [0:QW];
  logic             db_v    [0:QW];
  logic [Sum2W-1:0] db_rem  [0:QW];
  logic [Sum2W-1:0] db_den  [0:QW];
  logic [QW-1:0]    db_q    [0:QW];
  logic [0:0]       db_side [0:QW];
  assign da_v[0]    = s6_v_r;
  assign da_rem[0]  = s6_d1_r;
  assign da_den[0]  = s6_s1_r;
  assign da_q[0]    = '0;
  assign da_side[0] = {s6_tir_r, s6_z1_r};
  assign db_v[0]    = s6_v_r;
  assign db_rem[0]  = s6_d2_r;
  assign db_den[0]  = s6_s2_r;
  assign db_q[0]    = '0;
  assign db_side[0] = s6_z2_r;

  generate
    for (genvar i = 0; i < QW; i++) begin : g_div
      fdr_div_cell #(.DW(Sum1W), .QW(QW), .SW(2), .FIRST(i == 0)) u_par (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(da_v[i]), .in_rem(da_rem[i]), .in_den(da_den[i]),
        .in_q(da_q[i]), .in_side(da_side[i]),
        .out_valid(da_v[i+1]), .out_rem(da_rem[i+1]), .out_den(da_den[i+1]),
        .out_q(da_q[i+1]), .out_side(da_side[i+1])
      );
      fdr_div_cell #(.DW(Sum2W), .QW(QW), .SW(1), .FIRST(i == 0)) u_perp (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(db_v[i]), .in_rem(db_rem[i]), .in_den(db_den[i]),
        .in_q(db_q[i]), .in_side(db_side[i]),
        .out_valid(db_v[i+1]), .out_rem(db_rem[i+1]), .out_den(db_den[i+1]),
        .out_q(db_q[i+1]), .out_side(db_side[i+1])
      );
    end
  endgenerate

  // square both ratios
  logic [QW-1:0]   q1, q2;
  logic            s8_v_r, s8_tir_r;
  logic [2*QW-1:0] s8_p1_r, s8_p2_r;
  assign q1 = da_side[QW][0] ? fdr_pkg::Q16_ONE : da_q[QW];
  assign q2 = db_side[QW][0] ? fdr_pkg::Q16_ONE : db_q[QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_v_r <= 1'b0;
    end else if (en) begin
      s8_v_r <= da_v[QW] && db_v[QW];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s8_tir_r <= da_side[QW][1];
      s8_p1_r  <= (2*QW)'(q1) * (2*QW)'(q1);
      s8_p2_r  <= (2*QW)'(q2) * (2*QW)'(q2);
    end
  end

  // mean, round, saturate; output register
  logic [2*QW:0] tot;
  logic [16:0]   refl;
  assign tot  = {1'b0, s8_p1_r} + {1'b0, s8_p2_r} + (2*QW+1)'(36'h2_0000);
  assign refl = tot[2*QW -: 17];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s8_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_total_internal <= s8_tir_r;
      if (s8_tir_r || (refl > {1'b0, fdr_pkg::Q15_ONE})) begin
        out_reflectance <= fdr_pkg::Q15_ONE;
      end else begin
        out_reflectance <= refl[15:0];
      end
    end
  end
endmodule
`default_nettype wire

[rtl/fdr_sqrt_cell.sv]
// One digit cell of the floor square root chain: one root bit per cell.
// Width constants come from fdr_pkg via the top level; no submodules.
`default_nettype none
module fdr_sqrt_cell #(
  parameter int unsigned RW = 16,
  parameter int unsigned SW = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [RW+1:0]     in_rem,
  input  wire logic [RW-1:0]     in_root,
  input  wire logic [2*RW-1:0]   in_rad,
  input  wire logic [SW-1:0]     in_side,
  output logic                   out_valid,
  output logic [RW+1:0]          out_rem,
  output logic [RW-1:0]          out_root,
  output logic [2*RW-1:0]        out_rad,
  output logic [SW-1:0]          out_side
);
  logic [RW+1:0] rem_sh, trial, rem_nxt;
  logic          ge;

  // bring down two radicand bits, try root*4+1
  always_comb begin
    rem_sh  = {in_rem[RW-1:0], in_rad[2*RW-1 -: 2]};
    trial   = {in_root, 2'b01};
    ge      = (rem_sh >= trial);
    rem_nxt = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= rem_nxt;
      out_root <= {in_root[RW-2:0], ge};
      out_rad  <= {in_rad[2*RW-3:0], 2'b00};
      out_side <= in_side;
    end
  end
endmodule
`default_nettype wire

[rtl/fdr_div_cell.sv]
// One cell of the restoring divider chain: one quotient bit per cell.
// Widths set by the top level from fdr_pkg; no submodules.
`default_nettype none
module fdr_div_cell #(
  parameter int unsigned DW    = 46,
  parameter int unsigned QW    = 17,
  parameter int unsigned SW    = 1,
  parameter bit          FIRST = 1'b0
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic [DW-1:0]  in_rem,
  input  wire logic [DW-1:0]  in_den,
  input  wire logic [QW-1:0]  in_q,
  input  wire logic [SW-1:0]  in_side,
  output logic                out_valid,
  output logic [DW-1:0]       out_rem,
  output logic [DW-1:0]       out_den,
  output logic [QW-1:0]       out_q,
  output logic [SW-1:0]       out_side
);
  logic [DW:0] r_sh, r_sub;
  logic        ge;

  // first cell compares the raw remainder, later cells double it
  generate
    if (FIRST) begin : g_first
      assign r_sh = {1'b0, in_rem};
    end else begin : g_next
      assign r_sh = {in_rem, 1'b0};
    end
  endgenerate

  always_comb begin
    ge    = (r_sh >= {1'b0, in_den});
    r_sub = ge ? (r_sh - {1'b0, in_den}) : r_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= r_sub[DW-1:0];
      out_den  <= in_den;
      out_q    <= {in_q[QW-2:0], ge};
      out_side <= in_side;
    end
  end
endmodule
`default_nettype wire

[bench/fdr_scoreboard.sv]
// Checker for the Fresnel reflectance core: watches both request channels,
// predicts each result in fixed point and compares it. Depends on fdr_pkg.
module fdr_scoreboard (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [15:0] in_cos_incident,
  input  wire logic [15:0] in_eta_ratio,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [15:0] out_reflectance,
  input  wire logic        out_total_internal,
  output int               fail_count,
  output int               pending_count
);
  typedef struct packed {
    logic [15:0] refl;
    logic        tir;
  } reflect_t;

  reflect_t pending_refl[$];

  // Floor square root, bit by bit.
  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Squared magnitude of (a-b)/(a+b), Q32.
  function automatic logic [63:0] ratio_sq(logic [63:0] a, logic [63:0] b);
    logic [63:0] diff;
    logic [63:0] sum;
    logic [63:0] q;
    diff = (a > b) ? a - b : b - a;
    sum = a + b;
    if (sum == 0) q = 64'd1 << 16;
    else q = (diff << 16) / sum;
    return q * q;
  endfunction

  function automatic reflect_t fresnel_of(logic [15:0] cosv, logic [15:0] eta);
    logic [63:0] c;
    logic [63:0] e;
    logic [63:0] si;
    logic [63:0] st;
    logic [63:0] ct;
    logic [63:0] tot;
    reflect_t r;
    c = cosv;
    e = eta;
    if (c > fdr_pkg::Q15_ONE) c = fdr_pkg::Q15_ONE;
    si = floor_root((64'd1 << 30) - c * c);
    st = e * si;
    if (st >= (64'd1 << 28)) begin
      r.refl = fdr_pkg::Q15_ONE;
      r.tir = 1'b1;
    end else begin
      ct = floor_root((64'd1 << 56) - st * st);
      tot = ratio_sq(e * c, ct) + ratio_sq(c << 26, e * ct);
      tot = (tot + (64'd1 << 17)) >> 18;
      if (tot > fdr_pkg::Q15_ONE) tot = fdr_pkg::Q15_ONE;
      r.refl = tot[15:0];
      r.tir = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reflect_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        pending_refl.push_back(fresnel_of(in_cos_incident, in_eta_ratio));
      if (out_valid && out_ready) begin
        if (pending_refl.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result refl=%0d", out_reflectance);
        end else begin
          want = pending_refl.pop_front();
          if (want.refl !== out_reflectance || want.tir !== out_total_internal) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected refl=%0d tir=%0b, got refl=%0d tir=%0b",
                       want.refl, want.tir, out_reflectance, out_total_internal);
          end
        end
      end
    end
    pending_count = pending_refl.size();
  end
endmodule

[bench/tb_fresnel_dielectric_reflectance_core.sv]
// Top of the Fresnel reflectance core bench: clock, reset, stimulus and verdict.
// Depends on fresnel_dielectric_reflectance_core and fdr_scoreboard.
module tb_fresnel_dielectric_reflectance_core;
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_cos_incident;
  logic [15:0] in_eta_ratio;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_reflectance;
  logic        out_total_internal;
  int          fail_count;
  int          pending_count;
  bit          stim_done;
  bit          hold_off;

  fresnel_dielectric_reflectance_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cos_incident(in_cos_incident), .in_eta_ratio(in_eta_ratio),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_reflectance(out_reflectance), .out_total_internal(out_total_internal)
  );

  fdr_scoreboard chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_cos_incident(in_cos_incident), .in_eta_ratio(in_eta_ratio),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_reflectance(out_reflectance), .out_total_internal(out_total_internal),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Send one request; idle gap first, then hold until accepted.
  task automatic send_request(logic [15:0] cosv, logic [15:0] eta, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cos_incident <= cosv;
    in_eta_ratio <= eta;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic int draw_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 11);
  endfunction

  // Random request: mostly physical ranges, some full-width noise.
  task automatic send_random();
    logic [15:0] cosv;
    logic [15:0] eta;
    case ($urandom_range(0, 5))
      0: cosv = $urandom_range(0, 65535);
      1: cosv = $urandom_range(30000, 32768);
      default: cosv = $urandom_range(0, 32768);
    endcase
    case ($urandom_range(0, 4))
      0: eta = $urandom_range(0, 65535);
      1: eta = $urandom_range(7000, 9500);
      2: eta = $urandom_range(1, 8192);
      default: eta = $urandom_range(8192, 16384);
    endcase
    send_request(cosv, eta, ($urandom_range(0, 2) == 0) ? 0 : draw_gap());
  endtask

  // Stimulus: directed corners, a burst under output hold-off, then random.
  initial begin
    in_valid = 0;
    in_cos_incident = 0;
    in_eta_ratio = 0;
    rst_n = 0;
    stim_done = 0;
    hold_off = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    send_request(16'd32768, 16'd8192, 0);
    send_request(16'd0, 16'd8192, 0);
    send_request(16'd0, 16'd0, 0);
    send_request(16'd32768, 16'd0, 0);
    send_request(16'd65535, 16'd65535, 0);
    send_request(16'd32769, 16'd12000, 0);
    send_request(16'd0, 16'd1, 0);
    send_request(16'd32768, 16'd65535, 0);
    send_request(16'd16384, 16'd65535, 0);
    send_request(16'd16384, 16'd12288, 0);
    send_request(16'd30000, 16'd10923, 0);
    send_request(16'd100, 16'd8191, 0);
    send_request(16'd1, 16'd6000, 0);
    send_request(16'd32767, 16'd1, 0);
    send_request(16'd20000, 16'd5461, 0);
    send_request(16'haaaa, 16'h5555, 0);
    send_request(16'h5555, 16'haaaa, 0);
    hold_off = 1;
    repeat (150) send_random();
    repeat (1200) send_random();
    in_valid <= 1'b0;
    stim_done = 1;
  end

  // Receiver: random ready, plus one long stall during the burst.
  initial begin
    int gap;
    out_ready = 0;
    wait (hold_off);
    out_ready <= 1'b0;
    repeat (300) @(posedge clk);
    forever begin
      if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        gap = draw_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        do @(posedge clk); while (!out_valid);
      end
    end
  end

  // Verdict once all requests drained.
  initial begin
    wait (stim_done);
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("fresnel_dielectric_reflectance_core regression: pass");
    end else begin
      $display("fresnel_dielectric_reflectance_core regression: fail");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("fresnel_dielectric_reflectance_core regression: fail");
    $finish;
  end
endmodule
